// ===== hw/rtl/qcr_pkg.sv =====
// shared constants for the quad clip and uv remap block
`timescale 1ns / 1ps

package qcr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int VCNT_BITS_DEF  = 16;

	// texture coordinates and tags are fixed 16-bit values
	localparam int TEX_BITS = 16;

	// one quotient bit per divide step
	localparam int DIV_CNT_BITS = $clog2(TEX_BITS);

	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_TOP    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_HEIGHT = 3'd4;

	localparam logic OP_DRAW        = 1'b0;
	localparam logic OP_FRAME_START = 1'b1;

endpackage

// ===== hw/rtl/qcr_if.sv =====
// quad input and vertex output channel interfaces
`timescale 1ns / 1ps

interface qcr_in_if #(
	parameter int COORD_BITS = qcr_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic signed [COORD_BITS-1:0]      quad_x;
	logic signed [COORD_BITS-1:0]      quad_y;
	logic signed [COORD_BITS-1:0]      quad_w;
	logic signed [COORD_BITS-1:0]      quad_h;
	logic [qcr_pkg::TEX_BITS-1:0]      u_start;
	logic [qcr_pkg::TEX_BITS-1:0]      v_start;
	logic [qcr_pkg::TEX_BITS-1:0]      u_end;
	logic [qcr_pkg::TEX_BITS-1:0]      v_end;
	logic [qcr_pkg::TEX_BITS-1:0]      texture_id;

	modport source (
		output valid, operation, quad_x, quad_y, quad_w, quad_h,
		output u_start, v_start, u_end, v_end, texture_id,
		input  ready
	);
	modport sink (
		input  valid, operation, quad_x, quad_y, quad_w, quad_h,
		input  u_start, v_start, u_end, v_end, texture_id,
		output ready
	);
endinterface

interface qcr_out_if #(
	parameter int COORD_BITS        = qcr_pkg::COORD_BITS_DEF,
	parameter int VERTEX_COUNT_BITS = qcr_pkg::VCNT_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [COORD_BITS-1:0]      pos_x;
	logic signed [COORD_BITS-1:0]      pos_y;
	logic [qcr_pkg::TEX_BITS-1:0]      tex_u;
	logic [qcr_pkg::TEX_BITS-1:0]      tex_v;
	logic signed [COORD_BITS-1:0]      orig_left;
	logic signed [COORD_BITS-1:0]      orig_top;
	logic signed [COORD_BITS-1:0]      orig_right;
	logic signed [COORD_BITS-1:0]      orig_bottom;
	logic [VERTEX_COUNT_BITS-1:0]      vertex_number;
	logic [qcr_pkg::TEX_BITS-1:0]      out_texture_id;
	logic                              last;

	modport source (
		output valid, pos_x, pos_y, tex_u, tex_v,
		output orig_left, orig_top, orig_right, orig_bottom,
		output vertex_number, out_texture_id, last,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, tex_u, tex_v,
		input  orig_left, orig_top, orig_right, orig_bottom,
		input  vertex_number, out_texture_id, last,
		output ready
	);
endinterface

// ===== hw/rtl/qcr_cfg_regs.sv =====
// clip rectangle configuration registers
`timescale 1ns / 1ps

module qcr_cfg_regs #(
	parameter int COORD_BITS = qcr_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  we,
	input  logic [qcr_pkg::CFG_INDEX_BITS-1:0]    index,
	input  logic [COORD_BITS-1:0]                 data,
	output logic                                  clip_enable,
	output logic signed [COORD_BITS-1:0]          clip_left,
	output logic signed [COORD_BITS-1:0]          clip_top,
	output logic [COORD_BITS-2:0]                 clip_width,
	output logic [COORD_BITS-2:0]                 clip_height
);

	logic                         enable_q;
	logic [COORD_BITS-1:0]        left_q;
	logic [COORD_BITS-1:0]        top_q;
	logic [COORD_BITS-2:0]        width_q;
	logic [COORD_BITS-2:0]        height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (we) begin
			case (index)
				qcr_pkg::CFG_CLIP_ENABLE: enable_q <= data[0];
				qcr_pkg::CFG_CLIP_LEFT:   left_q   <= data;
				qcr_pkg::CFG_CLIP_TOP:    top_q    <= data;
				qcr_pkg::CFG_CLIP_WIDTH:  width_q  <= data[COORD_BITS-2:0];
				qcr_pkg::CFG_CLIP_HEIGHT: height_q <= data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	assign clip_enable = enable_q;
	assign clip_left   = left_q;
	assign clip_top    = top_q;
	assign clip_width  = width_q;
	assign clip_height = height_q;

endmodule

// ===== hw/rtl/qcr_remap_unit.sv =====
// shared texture remap unit: one multiply then a bit-serial divide
`timescale 1ns / 1ps

module qcr_remap_unit #(
	parameter int COORD_BITS = qcr_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [COORD_BITS-2:0]              off,
	input  logic [COORD_BITS-2:0]              len,
	input  logic [qcr_pkg::TEX_BITS-1:0]       t0,
	input  logic [qcr_pkg::TEX_BITS-1:0]       t1,
	output logic                               done,
	output logic [qcr_pkg::TEX_BITS-1:0]       result
);

	localparam int TB = qcr_pkg::TEX_BITS;
	localparam int PB = COORD_BITS - 1 + TB;

	typedef enum logic [1:0] {R_IDLE, R_MUL, R_DIV, R_FIN} rstate_t;

	rstate_t                          state_q;
	logic [COORD_BITS-2:0]            off_q;
	logic [COORD_BITS-2:0]            len_q;
	logic [TB-1:0]                    t0_q;
	logic [TB-1:0]                    mag_q;
	logic                             neg_q;
	logic [COORD_BITS-2:0]            rem_q;
	logic [TB-1:0]                    low_q;
	logic [TB-1:0]                    quot_q;
	logic [qcr_pkg::DIV_CNT_BITS-1:0] cnt_q;

	logic [PB-1:0]                    prod;
	logic [COORD_BITS-1:0]            trial;
	logic [COORD_BITS-1:0]            len_ext;
	logic                             ge;
	logic [COORD_BITS-1:0]            diff;

	assign prod    = PB'(off_q) * PB'(mag_q);
	assign trial   = {rem_q, low_q[TB-1]};
	assign len_ext = {1'b0, len_q};
	assign ge      = trial >= len_ext;
	assign diff    = trial - len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			off_q   <= '0;
			len_q   <= '0;
			t0_q    <= '0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			low_q   <= '0;
			quot_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (start) begin
						off_q   <= off;
						len_q   <= len;
						t0_q    <= t0;
						neg_q   <= t1 < t0;
						mag_q   <= (t1 < t0) ? (t0 - t1) : (t1 - t0);
						state_q <= R_MUL;
					end
				end
				R_MUL: begin
					// product < len * 2^16, so the high part is already below len
					rem_q   <= prod[PB-1:TB];
					low_q   <= prod[TB-1:0];
					quot_q  <= '0;
					cnt_q   <= '0;
					state_q <= R_DIV;
				end
				R_DIV: begin
					rem_q  <= ge ? diff[COORD_BITS-2:0] : trial[COORD_BITS-2:0];
					low_q  <= {low_q[TB-2:0], 1'b0};
					quot_q <= {quot_q[TB-2:0], ge};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == qcr_pkg::DIV_CNT_BITS'(TB - 1)) begin
						state_q <= R_FIN;
					end
				end
				R_FIN: begin
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// magnitude divide truncates toward zero, sign applied afterwards
	assign done   = state_q == R_FIN;
	assign result = neg_q ? (t0_q - quot_q) : (t0_q + quot_q);

endmodule

// ===== hw/rtl/quad_clip_uv_remap.sv =====
// top level: scissor clip of a textured quad with uv remap, four vertices out
//
//  channel   dir  handshake          carries
//  cfg       in   cfg_we             clip register index and value
//  in_ch     in   valid / ready      one quad or a frame start
//  out_ch    out  valid / ready      one corner vertex per transfer
//
// a clipped quad runs four remaps on one shared multiply/divide unit, each made of
// start, multiply, 16 divide steps and finish, then gives one vertex per cycle while
// out_ch is ready; an unclipped quad goes from the clip state straight to its vertices,
// and frame starts and culled quads give no vertices.
// in_ch is ready only while idle; out_ch stalls hold the vertex in place.
// reset clears the clip registers and the vertex counter.
`timescale 1ns / 1ps

module quad_clip_uv_remap #(
	parameter int COORD_BITS        = qcr_pkg::COORD_BITS_DEF,
	parameter int VERTEX_COUNT_BITS = qcr_pkg::VCNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data,
	qcr_in_if.sink                             in_ch,
	qcr_out_if.source                          out_ch
);

	localparam int CB = COORD_BITS;
	localparam int TB = qcr_pkg::TEX_BITS;

	typedef enum logic [2:0] {S_IDLE, S_CLIP, S_RSTART, S_RWAIT, S_EMIT} state_t;

	function automatic logic signed [CB-1:0] sat_coord(input logic signed [CB:0] v);
		logic signed [CB-1:0] r;
		if (v[CB] != v[CB-1]) begin
			r = v[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else begin
			r = v[CB-1:0];
		end
		return r;
	endfunction

	logic                     clip_enable;
	logic signed [CB-1:0]     clip_left;
	logic signed [CB-1:0]     clip_top;
	logic [CB-2:0]            clip_width;
	logic [CB-2:0]            clip_height;

	state_t                   state_q;
	logic [1:0]               idx_q;
	logic [VERTEX_COUNT_BITS-1:0] vcnt_q;
	logic signed [CB-1:0]     qx_q, qy_q, qw_q, qh_q;
	logic [TB-1:0]            u0_q, v0_q, u1_q, v1_q, tex_q;
	logic [TB-1:0]            tex_hold_q;
	logic signed [CB:0]       x1_q, x2_q, y1_q, y2_q;
	logic signed [CB-1:0]     orig_right_q, orig_bottom_q;

	logic signed [CB:0]       qx_e, qy_e, qw_e, qh_e, cl_e, ct_e;
	logic signed [CB:0]       qr, qb, cr, cb, cx1, cx2, cy1, cy2;
	logic                     do_clip;

	logic                     r_start;
	logic                     r_done;
	logic [TB-1:0]            r_result;
	logic signed [CB:0]       r_off_full;
	logic [CB-2:0]            r_len;
	logic [TB-1:0]            r_t0, r_t1;

	logic                     in_xfer, out_xfer;

	qcr_cfg_regs #(.COORD_BITS(CB)) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.we          (cfg_we),
		.index       (cfg_index),
		.data        (cfg_data),
		.clip_enable (clip_enable),
		.clip_left   (clip_left),
		.clip_top    (clip_top),
		.clip_width  (clip_width),
		.clip_height (clip_height)
	);

	qcr_remap_unit #(.COORD_BITS(CB)) u_remap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (r_start),
		.off    (r_off_full[CB-2:0]),
		.len    (r_len),
		.t0     (r_t0),
		.t1     (r_t1),
		.done   (r_done),
		.result (r_result)
	);

	// exact edges, one bit wider than a coordinate
	assign qx_e = {qx_q[CB-1], qx_q};
	assign qy_e = {qy_q[CB-1], qy_q};
	assign qw_e = {qw_q[CB-1], qw_q};
	assign qh_e = {qh_q[CB-1], qh_q};
	assign cl_e = {clip_left[CB-1], clip_left};
	assign ct_e = {clip_top[CB-1], clip_top};
	assign qr   = qx_e + qw_e;
	assign qb   = qy_e + qh_e;
	assign cr   = cl_e + {2'b00, clip_width};
	assign cb   = ct_e + {2'b00, clip_height};
	assign cx1  = (qx_e > cl_e) ? qx_e : cl_e;
	assign cy1  = (qy_e > ct_e) ? qy_e : ct_e;
	assign cx2  = (qr < cr) ? qr : cr;
	assign cy2  = (qb < cb) ? qb : cb;

	assign do_clip = clip_enable && !qw_q[CB-1] && (qw_q != '0)
		&& !qh_q[CB-1] && (qh_q != '0);

	// remap operand select: left u, right u, top v, bottom v
	always_comb begin
		case (idx_q)
			2'd0: r_off_full = x1_q - qx_e;
			2'd1: r_off_full = x2_q - qx_e;
			2'd2: r_off_full = y1_q - qy_e;
			2'd3: r_off_full = y2_q - qy_e;
			default: r_off_full = '0;
		endcase
	end
	assign r_len   = idx_q[1] ? qh_q[CB-2:0] : qw_q[CB-2:0];
	assign r_t0    = idx_q[1] ? v0_q : u0_q;
	assign r_t1    = idx_q[1] ? v1_q : u1_q;
	assign r_start = state_q == S_RSTART;

	assign in_ch.ready = state_q == S_IDLE;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			vcnt_q        <= '0;
			qx_q          <= '0;
			qy_q          <= '0;
			qw_q          <= '0;
			qh_q          <= '0;
			u0_q          <= '0;
			v0_q          <= '0;
			u1_q          <= '0;
			v1_q          <= '0;
			tex_q         <= '0;
			tex_hold_q    <= '0;
			x1_q          <= '0;
			x2_q          <= '0;
			y1_q          <= '0;
			y2_q          <= '0;
			orig_right_q  <= '0;
			orig_bottom_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_ch.operation == qcr_pkg::OP_FRAME_START) begin
							vcnt_q <= '0;
						end else begin
							qx_q    <= in_ch.quad_x;
							qy_q    <= in_ch.quad_y;
							qw_q    <= in_ch.quad_w;
							qh_q    <= in_ch.quad_h;
							u0_q    <= in_ch.u_start;
							v0_q    <= in_ch.v_start;
							u1_q    <= in_ch.u_end;
							v1_q    <= in_ch.v_end;
							tex_q   <= in_ch.texture_id;
							state_q <= S_CLIP;
						end
					end
				end
				S_CLIP: begin
					orig_right_q  <= sat_coord(qr);
					orig_bottom_q <= sat_coord(qb);
					idx_q         <= '0;
					if (do_clip) begin
						x1_q <= cx1;
						x2_q <= cx2;
						y1_q <= cy1;
						y2_q <= cy2;
						// empty intersection: quad culled, counter untouched
						if (cx1 >= cx2 || cy1 >= cy2) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RSTART;
						end
					end else begin
						x1_q    <= qx_e;
						x2_q    <= qr;
						y1_q    <= qy_e;
						y2_q    <= qb;
						state_q <= S_EMIT;
					end
				end
				S_RSTART: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (r_done) begin
						// both remaps of an axis need the original span, so the
						// first result waits until the second is done
						case (idx_q)
							2'd0: tex_hold_q <= r_result;
							2'd1: begin
								u0_q <= tex_hold_q;
								u1_q <= r_result;
							end
							2'd2: tex_hold_q <= r_result;
							2'd3: begin
								v0_q <= tex_hold_q;
								v1_q <= r_result;
							end
							default: ;
						endcase
						idx_q <= idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_RSTART;
						end
					end
				end
				S_EMIT: begin
					if (out_xfer) begin
						vcnt_q <= vcnt_q + 1'b1;
						idx_q  <= idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// idx_q walks the corners: bit 0 picks right, bit 1 picks bottom
	assign out_ch.valid          = state_q == S_EMIT;
	assign out_ch.pos_x          = sat_coord(idx_q[0] ? x2_q : x1_q);
	assign out_ch.pos_y          = sat_coord(idx_q[1] ? y2_q : y1_q);
	assign out_ch.tex_u          = idx_q[0] ? u1_q : u0_q;
	assign out_ch.tex_v          = idx_q[1] ? v1_q : v0_q;
	assign out_ch.orig_left      = qx_q;
	assign out_ch.orig_top       = qy_q;
	assign out_ch.orig_right     = orig_right_q;
	assign out_ch.orig_bottom    = orig_bottom_q;
	assign out_ch.vertex_number  = vcnt_q;
	assign out_ch.out_texture_id = tex_q;
	assign out_ch.last           = idx_q == 2'd3;

endmodule

// ===== sim/tb_quad_clip_uv_remap.sv =====
// testbench for quad_clip_uv_remap: random and directed quads checked against a local clip model
`timescale 1ns / 1ps

module tb_quad_clip_uv_remap;

	localparam int CB = qcr_pkg::COORD_BITS_DEF;
	localparam int VB = qcr_pkg::VCNT_BITS_DEF;
	localparam int TB = qcr_pkg::TEX_BITS;
	localparam int IB = qcr_pkg::CFG_INDEX_BITS;
	localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int IDLE_PCT = 23;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic                 operation;
		logic signed [CB-1:0] quad_x, quad_y, quad_w, quad_h;
		logic [TB-1:0]        u_start, v_start, u_end, v_end, texture_id;
	} quad_t;

	typedef struct {
		logic signed [CB-1:0] pos_x, pos_y;
		logic [TB-1:0]        tex_u, tex_v;
		logic signed [CB-1:0] orig_left, orig_top, orig_right, orig_bottom;
		logic [VB-1:0]        vertex_number;
		logic [TB-1:0]        out_texture_id;
		logic                 last;
	} vertex_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IB-1:0] cfg_index;
	logic [CB-1:0] cfg_data;
	bit steady;
	int stall_cycles;

	qcr_in_if in_bus ();
	qcr_out_if out_bus ();

	quad_clip_uv_remap uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_bus),
		.out_ch(out_bus)
	);

	function automatic logic signed [CB-1:0] clamp_coord(longint v);
		if (v > CMAX)
			return CMAX[CB-1:0];
		if (v < CMIN)
			return CMIN[CB-1:0];
		return v[CB-1:0];
	endfunction

	// start + offset share of the texture span, truncated toward zero
	function automatic longint remap_tex(longint t0, longint t1, longint off, longint len);
		return t0 + (off * (t1 - t0)) / len;
	endfunction

	class quad_scoreboard;
		bit clip_on;
		logic signed [CB-1:0] clip_x, clip_y;
		logic [CB-2:0] clip_w, clip_h;
		logic [VB-1:0] vcount;
		vertex_t pending[$];
		int errors, quads, frames, culled, clipped, checked;

		function new();
			clip_on = 0;
			clip_x = '0;
			clip_y = '0;
			clip_w = '0;
			clip_h = '0;
			vcount = '0;
		endfunction

		function void write_reg(logic [IB-1:0] idx, logic [CB-1:0] data);
			case (idx)
				qcr_pkg::CFG_CLIP_ENABLE: clip_on = data[0];
				qcr_pkg::CFG_CLIP_LEFT: clip_x = data;
				qcr_pkg::CFG_CLIP_TOP: clip_y = data;
				qcr_pkg::CFG_CLIP_WIDTH: clip_w = data[CB-2:0];
				qcr_pkg::CFG_CLIP_HEIGHT: clip_h = data[CB-2:0];
				default: ;
			endcase
		endfunction

		function void fail(string msg);
			errors++;
			$error("%s", msg);
		endfunction

		// builds the four corner vertices a quad should produce
		function void note_quad(quad_t q);
			longint qx, qy, qw, qh, u0, v0, u1, v1;
			longint x1, y1, x2, y2, tu0, tu1, tv0, tv1, cl, ct, cw, ch;
			vertex_t vx;
			if (q.operation == qcr_pkg::OP_FRAME_START) begin
				frames++;
				vcount = '0;
				return;
			end
			quads++;
			qx = q.quad_x;
			qy = q.quad_y;
			qw = q.quad_w;
			qh = q.quad_h;
			u0 = q.u_start;
			v0 = q.v_start;
			u1 = q.u_end;
			v1 = q.v_end;
			x1 = qx;
			y1 = qy;
			x2 = qx + qw;
			y2 = qy + qh;
			tu0 = u0;
			tu1 = u1;
			tv0 = v0;
			tv1 = v1;
			if (clip_on && qw > 0 && qh > 0) begin
				cl = clip_x;
				ct = clip_y;
				cw = clip_w;
				ch = clip_h;
				x1 = (qx > cl) ? qx : cl;
				y1 = (qy > ct) ? qy : ct;
				x2 = (qx + qw < cl + cw) ? qx + qw : cl + cw;
				y2 = (qy + qh < ct + ch) ? qy + qh : ct + ch;
				if (x1 >= x2 || y1 >= y2) begin
					culled++;
					return;
				end
				clipped++;
				tu0 = remap_tex(u0, u1, x1 - qx, qw);
				tu1 = remap_tex(u0, u1, x2 - qx, qw);
				tv0 = remap_tex(v0, v1, y1 - qy, qh);
				tv1 = remap_tex(v0, v1, y2 - qy, qh);
			end
			for (int k = 0; k < 4; k++) begin
				vx.pos_x = clamp_coord(k[0] ? x2 : x1);
				vx.pos_y = clamp_coord(k[1] ? y2 : y1);
				vx.tex_u = TB'(k[0] ? tu1 : tu0);
				vx.tex_v = TB'(k[1] ? tv1 : tv0);
				vx.orig_left = clamp_coord(qx);
				vx.orig_top = clamp_coord(qy);
				vx.orig_right = clamp_coord(qx + qw);
				vx.orig_bottom = clamp_coord(qy + qh);
				vx.vertex_number = vcount;
				vx.out_texture_id = q.texture_id;
				vx.last = (k == 3);
				pending = {pending, vx};
				vcount = vcount + 1'b1;
			end
		endfunction

		function void check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
			if (a !== e)
				fail($sformatf("%s: expected %0d, got %0d", name, e, a));
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t e;
			if (pending.size() == 0) begin
				fail($sformatf("vertex with no quad pending: pos %0d,%0d number %0d",
					got.pos_x, got.pos_y, got.vertex_number));
				return;
			end
			e = pending.pop_front();
			checked++;
			check_field("pos_x", e.pos_x, got.pos_x);
			check_field("pos_y", e.pos_y, got.pos_y);
			check_field("tex_u", e.tex_u, got.tex_u);
			check_field("tex_v", e.tex_v, got.tex_v);
			check_field("orig_left", e.orig_left, got.orig_left);
			check_field("orig_top", e.orig_top, got.orig_top);
			check_field("orig_right", e.orig_right, got.orig_right);
			check_field("orig_bottom", e.orig_bottom, got.orig_bottom);
			check_field("vertex_number", e.vertex_number, got.vertex_number);
			check_field("out_texture_id", e.out_texture_id, got.out_texture_id);
			check_field("last", e.last, got.last);
		endfunction
	endclass

	quad_scoreboard sb = new();

	always #2 clk = ~clk;

	// output side: random backpressure
	always @(posedge clk) begin
		if (!arst_n)
			out_bus.ready <= 1'b0;
		else
			out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : vertex_monitor
		vertex_t got;
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			got.pos_x = out_bus.pos_x;
			got.pos_y = out_bus.pos_y;
			got.tex_u = out_bus.tex_u;
			got.tex_v = out_bus.tex_v;
			got.orig_left = out_bus.orig_left;
			got.orig_top = out_bus.orig_top;
			got.orig_right = out_bus.orig_right;
			got.orig_bottom = out_bus.orig_bottom;
			got.vertex_number = out_bus.vertex_number;
			got.out_texture_id = out_bus.out_texture_id;
			got.last = out_bus.last;
			sb.check_vertex(got);
		end
	end

	// no transfer on either channel for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic quad_t mk_quad(logic op, int x, int y, int w, int h,
		int u0, int v0, int u1, int v1, int tid);
		quad_t q;
		q.operation = op;
		q.quad_x = x[CB-1:0];
		q.quad_y = y[CB-1:0];
		q.quad_w = w[CB-1:0];
		q.quad_h = h[CB-1:0];
		q.u_start = u0[TB-1:0];
		q.v_start = v0[TB-1:0];
		q.u_end = u1[TB-1:0];
		q.v_end = v1[TB-1:0];
		q.texture_id = tid[TB-1:0];
		return q;
	endfunction

	function automatic logic signed [CB-1:0] around(longint mid, longint spread);
		return clamp_coord(mid - spread + longint'($urandom_range(0, 32'(2 * spread))));
	endfunction

	// mostly quads that overlap the clip window, plus noise and degenerate sizes
	function automatic quad_t random_quad();
		quad_t q;
		int r;
		longint cl, ct, cw, ch, sx, sy;
		cl = sb.clip_x;
		ct = sb.clip_y;
		cw = sb.clip_w;
		ch = sb.clip_h;
		sx = cw / 2 + 256;
		sy = ch / 2 + 256;
		q.operation = ($urandom_range(0, 99) < 4) ? qcr_pkg::OP_FRAME_START : qcr_pkg::OP_DRAW;
		q.u_start = TB'($urandom);
		q.v_start = TB'($urandom);
		q.u_end = TB'($urandom);
		q.v_end = TB'($urandom);
		q.texture_id = TB'($urandom);
		r = $urandom_range(0, 99);
		if (r < 12) begin
			q.quad_x = CB'($urandom);
			q.quad_y = CB'($urandom);
			q.quad_w = CB'($urandom);
			q.quad_h = CB'($urandom);
		end else begin
			q.quad_x = around(cl + cw / 2, cw / 2 + sx);
			q.quad_y = around(ct + ch / 2, ch / 2 + sy);
			if ($urandom_range(0, 3) == 0) begin
				q.quad_w = CB'($urandom_range(1, 32));
				q.quad_h = CB'($urandom_range(1, 32));
			end else begin
				q.quad_w = clamp_coord(longint'($urandom_range(1, 32'(cw + sx))));
				q.quad_h = clamp_coord(longint'($urandom_range(1, 32'(ch + sy))));
			end
			// zero or negative size skips clipping
			if (r < 20)
				q.quad_w = clamp_coord(-longint'($urandom_range(0, 3000)));
			else if (r < 26)
				q.quad_h = clamp_coord(-longint'($urandom_range(0, 3000)));
		end
		return q;
	endfunction

	task automatic send_quad(quad_t q);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_bus.valid <= 1'b0;
			do
				@(posedge clk);
			while (!steady && $urandom_range(0, 99) < IDLE_PCT);
		end
		in_bus.valid <= 1'b1;
		in_bus.operation <= q.operation;
		in_bus.quad_x <= q.quad_x;
		in_bus.quad_y <= q.quad_y;
		in_bus.quad_w <= q.quad_w;
		in_bus.quad_h <= q.quad_h;
		in_bus.u_start <= q.u_start;
		in_bus.v_start <= q.v_start;
		in_bus.u_end <= q.u_end;
		in_bus.v_end <= q.v_end;
		in_bus.texture_id <= q.texture_id;
		do
			@(posedge clk);
		while (!in_bus.ready);
		sb.note_quad(q);
	endtask

	task automatic send_list(quad_t qs[$]);
		foreach (qs[i])
			send_quad(qs[i]);
		in_bus.valid <= 1'b0;
	endtask

	task automatic send_random(int count, int steady_count);
		for (int i = 0; i < count; i++) begin
			steady = (i < steady_count);
			send_quad(random_quad());
		end
		steady = 0;
		in_bus.valid <= 1'b0;
	endtask

	// culled quads and frame starts leave nothing to wait on, so allow a few cycles
	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [IB-1:0] idx, logic [CB-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_clip(logic en, int left, int top, int w, int h);
		wait_drained();
		cfg_write(qcr_pkg::CFG_CLIP_ENABLE, {{(CB-1){1'b0}}, en});
		cfg_write(qcr_pkg::CFG_CLIP_LEFT, left[CB-1:0]);
		cfg_write(qcr_pkg::CFG_CLIP_TOP, top[CB-1:0]);
		cfg_write(qcr_pkg::CFG_CLIP_WIDTH, {1'b0, w[CB-2:0]});
		cfg_write(qcr_pkg::CFG_CLIP_HEIGHT, {1'b0, h[CB-2:0]});
		cfg_we <= 1'b0;
	endtask

	initial begin
		quad_t qs[$];
		quad_t q;
		clk = 1'b0;
		steady = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_bus.valid <= 1'b0;
		in_bus.operation <= qcr_pkg::OP_DRAW;
		in_bus.quad_x <= '0;
		in_bus.quad_y <= '0;
		in_bus.quad_w <= '0;
		in_bus.quad_h <= '0;
		in_bus.u_start <= '0;
		in_bus.v_start <= '0;
		in_bus.u_end <= '0;
		in_bus.v_end <= '0;
		in_bus.texture_id <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// clipping off after reset: pass-through and saturated bounds
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 0, 0, 16, 16, 0, 0, 'hFFFF, 'hFFFF, 'h0001)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 32767, 32767, 32767, 32767,
			'hFFFF, 'hFFFF, 0, 0, 'hFFFF)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, -32768, -32768, -32768, -32768,
			0, 'hFFFF, 'hFFFF, 0, 0)};
		qs = {qs, mk_quad(qcr_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 100, 200, 0, -5,
			'h1234, 'h5678, 'h9ABC, 'hDEF0, 'h00AA)};
		send_list(qs);
		send_random(40, 0);

		// typical window: inside, partial, reversed uv, culled, degenerate sizes
		set_clip(1'b1, -1600, 320, 3200, 2400);
		qs.delete();
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 0, 800, 320, 320, 0, 0, 'hFFFF, 'hFFFF, 2)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, -3200, 0, 3360, 1600,
			'h1000, 'h2000, 'hF000, 'hE000, 3)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, -2000, 100, 4000, 4000,
			'hF000, 'hFFFF, 'h0100, 0, 4)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 5000, 800, 100, 100, 0, 0, 'hFFFF, 'hFFFF, 5)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 0, -5000, 100, 100, 0, 0, 'hFFFF, 'hFFFF, 6)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 1600, 800, 100, 100, 0, 0, 'hFFFF, 'hFFFF, 7)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 10000, 800, 0, 50,
			'h0F0F, 'hF0F0, 'h0000, 'hFFFF, 8)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 0, 800, 100, -300,
			'h0001, 'h0002, 'h0003, 'h0004, 9)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, -16000, -16000, 32767, 32767,
			0, 'hFFFF, 'hFFFF, 0, 10)};
		qs = {qs, mk_quad(qcr_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		send_list(qs);
		send_random(160, 60);

		// window past the top of the range: clipped corners saturate
		set_clip(1'b1, 32767, 32767, 32767, 32767);
		qs.delete();
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 32000, 32000, 32767, 32767,
			0, 0, 'hFFFF, 'hFFFF, 11)};
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, 32767, 32767, 1, 1,
			'h8000, 'h8000, 'h7FFF, 'h7FFF, 12)};
		send_list(qs);
		send_random(60, 0);

		// window at the bottom of the range
		set_clip(1'b1, -32768, -32768, 32767, 32767);
		qs.delete();
		qs = {qs, mk_quad(qcr_pkg::OP_DRAW, -32768, -32768, 32767, 32767,
			0, 0, 'hFFFF, 'hFFFF, 13)};
		send_list(qs);
		send_random(50, 0);

		// empty window culls every positive-size quad
		set_clip(1'b1, 0, 0, 0, 0);
		send_random(20, 0);

		// clipping off, short back-to-back run after a frame start
		set_clip(1'b0, 0, 0, 0, 0);
		steady = 1;
		send_quad(mk_quad(qcr_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 12; i++) begin
			q = random_quad();
			q.operation = qcr_pkg::OP_DRAW;
			send_quad(q);
		end
		steady = 0;
		in_bus.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d quads (%0d clipped, %0d culled) and %0d frame starts",
			sb.quads, sb.clipped, sb.culled, sb.frames);
		$display("%0d vertices checked over five clip windows", sb.checked);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/qcr_pkg.sv
hw/rtl/qcr_if.sv
hw/rtl/qcr_cfg_regs.sv
hw/rtl/qcr_remap_unit.sv
hw/rtl/quad_clip_uv_remap.sv
sim/tb_quad_clip_uv_remap.sv
